@@ hdl/efg_pkg.sv @@
// Shared types, codes and default sizes for the event flag group engine.
package efg_pkg;

    localparam int EFG_WAITER_SLOTS = 8;
    localparam int EFG_FLAG_BITS    = 16;

    localparam int MODE_W    = 2;
    localparam int WAITER_W  = 3;
    localparam int MASK_W    = 16;
    localparam int WKIND_W   = 2;
    localparam int KIND_W    = 3;
    localparam int SLOT_W    = 3;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    localparam logic [MODE_W-1:0] MODE_WAIT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd3;

    localparam logic [WKIND_W-1:0] WK_ALL_SET   = 2'd0;
    localparam logic [WKIND_W-1:0] WK_ALL_CLEAR = 2'd1;
    localparam logic [WKIND_W-1:0] WK_ANY_SET   = 2'd2;
    localparam logic [WKIND_W-1:0] WK_ANY_CLEAR = 2'd3;

    localparam logic [KIND_W-1:0] KIND_MATCHED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BLOCKED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WOKEN   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EMIT
    } state_t;

endpackage

@@ hdl/event_flag_group_engine.sv @@
// Event flag group engine: flag word, waiter slot table and a slot sequencer.
// A wait, clear or timeout beat goes from idle to the exec state, which loads its result beat
// into the output register; a set beat scans WAITER_SLOTS slots, one per cycle, through the shared
// match unit, then walks them again in the emit state: one done beat when nobody wakes, else one
// woken beat per released slot; output stalls hold exec and emit; tready is high only in idle.
// Reset (aresetn low, synchronous) clears the flag word, all waiting bits and the output.
module event_flag_group_engine
    import efg_pkg::*;
#(
    parameter int WAITER_SLOTS = EFG_WAITER_SLOTS,
    parameter int FLAG_BITS    = EFG_FLAG_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: waiter[2:0], mask[18:3], wait_kind[20:19], zero fill [23:21].
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: mode[1:0].
    input  logic [MODE_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: slot[2:0], released_mask[18:3], flags_now[34:19], zero fill [39:35].
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // tuser: kind[2:0].
    output logic [KIND_W-1:0]     m_axis_tuser,
    // tlast: last result beat caused by one input beat.
    output logic                  m_axis_tlast
);

    localparam int IDX_W = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WAITER_SLOTS - 1);

    // Input beat fields.
    logic [WAITER_W-1:0]  in_waiter;
    logic [MASK_W-1:0]    in_mask;
    logic [WKIND_W-1:0]   in_wkind;
    logic [63:0]          in_mask_wide;
    logic [FLAG_BITS-1:0] in_mask_fb;

    assign in_waiter    = s_axis_tdata[2:0];
    assign in_mask      = s_axis_tdata[18:3];
    assign in_wkind     = s_axis_tdata[20:19];
    assign in_mask_wide = 64'(in_mask);
    assign in_mask_fb   = in_mask_wide[FLAG_BITS-1:0];

    // Control and flag state.
    state_t               state_reg, state_next;
    logic [FLAG_BITS-1:0] flag_reg, flag_next;
    logic [FLAG_BITS-1:0] scan_flags_reg, scan_flags_next;
    logic [FLAG_BITS-1:0] new_flags_reg, new_flags_next;
    logic [WAITER_SLOTS-1:0] waiting_reg, waiting_next;
    logic [WAITER_SLOTS-1:0] woke_reg, woke_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;

    // Captured input beat.
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [WAITER_W-1:0]  waiter_reg, waiter_next;
    logic [FLAG_BITS-1:0] mask_reg, mask_next;
    logic [WKIND_W-1:0]   wkind_reg, wkind_next;

    // Output register.
    logic                 m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]    m_kind_reg, m_kind_next;
    logic [SLOT_W-1:0]    m_slot_reg, m_slot_next;
    logic [MASK_W-1:0]    m_rel_reg, m_rel_next;
    logic [MASK_W-1:0]    m_flags_reg, m_flags_next;
    logic                 m_last_reg, m_last_next;

    // Slot table: mask and wait kind, one read port registered at idx_next.
    logic [FLAG_BITS-1:0] slot_mask_mem [WAITER_SLOTS];
    logic [WKIND_W-1:0]   slot_kind_mem [WAITER_SLOTS];
    logic [FLAG_BITS-1:0] rd_mask_reg;
    logic [WKIND_W-1:0]   rd_kind_reg;
    logic                 mem_we;

    // Shared match unit operands and results.
    logic [FLAG_BITS-1:0] mu_flags, mu_mask, mu_and, mu_rel;
    logic [WKIND_W-1:0]   mu_kind;
    logic                 mu_hit, mu_clears;

    logic [IDX_W-1:0]     widx;
    logic                 w_in_range;
    logic                 out_free;
    logic [63:0]          rel_wide, flags_wide;
    logic [WAITER_SLOTS-1:0] idx_onehot;

    assign widx       = IDX_W'(waiter_reg);
    assign w_in_range = (32'(waiter_reg) < WAITER_SLOTS);
    assign out_free   = !m_valid_reg || m_axis_tready;
    assign idx_onehot = WAITER_SLOTS'(1) << idx_reg;

    // One match unit serves the immediate test of a wait and the per-slot tests of a set.
    always_comb begin
        if (state_reg == ST_EXEC) begin
            mu_flags = flag_reg;
            mu_mask  = mask_reg;
            mu_kind  = wkind_reg;
        end else begin
            mu_flags = scan_flags_reg;
            mu_mask  = rd_mask_reg;
            mu_kind  = rd_kind_reg;
        end
        mu_and    = mu_flags & mu_mask;
        mu_clears = (mu_kind == WK_ALL_CLEAR) || (mu_kind == WK_ANY_CLEAR);
        if ((mu_kind == WK_ANY_SET) || (mu_kind == WK_ANY_CLEAR)) begin
            mu_rel = mu_and;
            mu_hit = (mu_and != '0);
        end else begin
            mu_rel = mu_mask;
            mu_hit = (mu_and == mu_mask);
        end
    end

    assign rel_wide = 64'(mu_rel);

    // Sequencer: next state, flag updates and result beats.
    always_comb begin
        state_next      = state_reg;
        flag_next       = flag_reg;
        scan_flags_next = scan_flags_reg;
        new_flags_next  = new_flags_reg;
        waiting_next    = waiting_reg;
        woke_next       = woke_reg;
        idx_next        = '0;
        mode_next       = mode_reg;
        waiter_next     = waiter_reg;
        mask_next       = mask_reg;
        wkind_next      = wkind_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_kind_next     = m_kind_reg;
        m_slot_next     = m_slot_reg;
        m_rel_next      = m_rel_reg;
        m_flags_next    = m_flags_reg;
        m_last_next     = m_last_reg;
        mem_we          = 1'b0;
        s_axis_tready   = 1'b0;
        flags_wide      = 64'(flag_reg);

        case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    mode_next   = s_axis_tuser;
                    waiter_next = in_waiter;
                    mask_next   = in_mask_fb;
                    wkind_next  = in_wkind;
                    if (s_axis_tuser == MODE_SET) begin
                        scan_flags_next = flag_reg | in_mask_fb;
                        new_flags_next  = flag_reg | in_mask_fb;
                        woke_next       = '0;
                        state_next      = ST_SCAN;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_slot_next  = waiter_reg;
                    m_rel_next   = '0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                    case (mode_reg)
                        MODE_WAIT: begin
                            if (!w_in_range || waiting_reg[widx]) begin
                                m_kind_next = KIND_ERROR;
                            end else if (mu_hit) begin
                                m_kind_next = KIND_MATCHED;
                                m_rel_next  = rel_wide[MASK_W-1:0];
                                if (mu_clears) begin
                                    flag_next = flag_reg & ~mask_reg;
                                end
                            end else begin
                                m_kind_next         = KIND_BLOCKED;
                                waiting_next[widx]  = 1'b1;
                                mem_we              = 1'b1;
                            end
                        end
                        MODE_CLEAR: begin
                            m_kind_next = KIND_DONE;
                            m_slot_next = '0;
                            flag_next   = flag_reg & ~mask_reg;
                        end
                        MODE_TIMEOUT: begin
                            if (!w_in_range || !waiting_reg[widx]) begin
                                m_kind_next = KIND_ERROR;
                            end else begin
                                m_kind_next        = KIND_TIMEOUT;
                                waiting_next[widx] = 1'b0;
                            end
                        end
                        default: begin
                            // Set beats never come through here; report them as done.
                            m_kind_next = KIND_DONE;
                            m_slot_next = '0;
                        end
                    endcase
                    flags_wide   = 64'(flag_next);
                    m_flags_next = flags_wide[MASK_W-1:0];
                end
            end

            ST_SCAN: begin
                // All slots are tested against the flags right after the OR; the
                // clear-type waiters only drop bits that this set beat brought.
                if (waiting_reg[idx_reg] && mu_hit) begin
                    woke_next[idx_reg]    = 1'b1;
                    waiting_next[idx_reg] = 1'b0;
                    if (mu_clears) begin
                        new_flags_next = new_flags_reg & ~(rd_mask_reg & mask_reg);
                    end
                end
                if (idx_reg == IDX_LAST) begin
                    flag_next  = new_flags_next;
                    state_next = ST_EMIT;
                    idx_next   = '0;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_EMIT: begin
                flags_wide = 64'(flag_reg);
                idx_next   = idx_reg;
                if (woke_reg == '0) begin
                    // Nobody was released: a single done beat.
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_kind_next  = KIND_DONE;
                        m_slot_next  = '0;
                        m_rel_next   = '0;
                        m_flags_next = flags_wide[MASK_W-1:0];
                        m_last_next  = 1'b1;
                        idx_next     = '0;
                        state_next   = ST_IDLE;
                    end
                end else if (!woke_reg[idx_reg]) begin
                    idx_next = idx_reg + 1'b1;
                end else if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_kind_next        = KIND_WOKEN;
                    m_slot_next        = SLOT_W'(idx_reg);
                    m_rel_next         = rel_wide[MASK_W-1:0];
                    m_flags_next       = flags_wide[MASK_W-1:0];
                    m_last_next        = ((woke_reg & ~idx_onehot) == '0);
                    woke_next[idx_reg] = 1'b0;
                    if ((woke_reg & ~idx_onehot) == '0) begin
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            flag_reg    <= '0;
            waiting_reg <= '0;
            woke_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            flag_reg    <= flag_next;
            waiting_reg <= waiting_next;
            woke_reg    <= woke_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        scan_flags_reg <= scan_flags_next;
        new_flags_reg  <= new_flags_next;
        mode_reg       <= mode_next;
        waiter_reg     <= waiter_next;
        mask_reg       <= mask_next;
        wkind_reg      <= wkind_next;
        m_kind_reg     <= m_kind_next;
        m_slot_reg     <= m_slot_next;
        m_rel_reg      <= m_rel_next;
        m_flags_reg    <= m_flags_next;
        m_last_reg     <= m_last_next;
    end

    // Slot table: written when a wait blocks, read one slot per cycle during a set.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mask_mem[widx] <= mask_reg;
            slot_kind_mem[widx] <= wkind_reg;
        end
        rd_mask_reg <= slot_mask_mem[idx_next];
        rd_kind_reg <= slot_kind_mem[idx_next];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, m_flags_reg, m_rel_reg, m_slot_reg};
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

@@ tb/tb_event_flag_group_engine.sv @@
// Self-checking testbench for the event flag group engine: directed table, then random traffic.
module tb_event_flag_group_engine;
    import efg_pkg::*;

    localparam int NSLOT       = EFG_WAITER_SLOTS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 2 * EFG_WAITER_SLOTS + 24;
    localparam int RANDOM_OPS  = 75;
    localparam int PLAN_ROWS   = 25;
    localparam int HOLD_AFTER  = 40;
    localparam int HOLD_CYCLES = 300;

    // One result beat as the engine should report it.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [MASK_W-1:0] released;
        logic [MASK_W-1:0] flags;
        logic              last;
    } reply_t;

    // One directed operation; the reply is typed in only where it is obvious.
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [WAITER_W-1:0] waiter;
        logic [MASK_W-1:0]   mask;
        logic [WKIND_W-1:0]  wkind;
        logic                typed;
        reply_t              reply;
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        // Clear of nothing right after reset.
        '{MODE_CLEAR, 3'd0, 16'h0000, WK_ALL_SET, 1'b1,
          '{KIND_DONE, 3'd0, 16'h0000, 16'h0000, 1'b1}},
        // An "all" wait on an empty mask matches at once and releases nothing.
        '{MODE_WAIT, 3'd0, 16'h0000, WK_ALL_SET, 1'b1,
          '{KIND_MATCHED, 3'd0, 16'h0000, 16'h0000, 1'b1}},
        // An "any" wait on an empty mask parks until its timeout.
        '{MODE_WAIT, 3'd1, 16'h0000, WK_ANY_SET, 1'b1,
          '{KIND_BLOCKED, 3'd1, 16'h0000, 16'h0000, 1'b1}},
        '{MODE_TIMEOUT, 3'd1, 16'h0000, WK_ALL_SET, 1'b1,
          '{KIND_TIMEOUT, 3'd1, 16'h0000, 16'h0000, 1'b1}},
        // Timeout of a slot that is no longer parked.
        '{MODE_TIMEOUT, 3'd1, 16'h0000, WK_ALL_SET, 1'b1,
          '{KIND_ERROR, 3'd1, 16'h0000, 16'h0000, 1'b1}},
        '{MODE_WAIT, 3'd2, 16'hFFFF, WK_ALL_SET, 1'b1,
          '{KIND_BLOCKED, 3'd2, 16'h0000, 16'h0000, 1'b1}},
        // Second wait on a parked slot.
        '{MODE_WAIT, 3'd2, 16'h0001, WK_ANY_SET, 1'b1,
          '{KIND_ERROR, 3'd2, 16'h0000, 16'h0000, 1'b1}},
        '{MODE_WAIT, 3'd3, 16'h00F0, WK_ANY_SET, 1'b0, '0},
        '{MODE_WAIT, 3'd4, 16'h0003, WK_ALL_CLEAR, 1'b0, '0},
        '{MODE_WAIT, 3'd5, 16'h0101, WK_ANY_CLEAR, 1'b0, '0},
        // Wakes slot 5 and takes back only the bit that this set brought.
        '{MODE_SET, 3'd0, 16'h0001, WK_ALL_SET, 1'b0, '0},
        '{MODE_SET, 3'd0, 16'h00F3, WK_ALL_SET, 1'b0, '0},
        // Wakes nobody: slot 2 still misses its low bits.
        '{MODE_SET, 3'd0, 16'hFF00, WK_ALL_SET, 1'b0, '0},
        '{MODE_SET, 3'd0, 16'h000F, WK_ALL_SET, 1'b0, '0},
        // Immediate "any clear" match removes the waited bit.
        '{MODE_WAIT, 3'd6, 16'h8000, WK_ANY_CLEAR, 1'b0, '0},
        '{MODE_CLEAR, 3'd0, 16'hFFFF, WK_ALL_SET, 1'b1,
          '{KIND_DONE, 3'd0, 16'h0000, 16'h0000, 1'b1}},
        // Park every slot, then one set releases all eight in slot order.
        '{MODE_WAIT, 3'd0, 16'h0001, WK_ALL_SET, 1'b0, '0},
        '{MODE_WAIT, 3'd1, 16'h8000, WK_ANY_SET, 1'b0, '0},
        '{MODE_WAIT, 3'd2, 16'h0F00, WK_ALL_CLEAR, 1'b0, '0},
        '{MODE_WAIT, 3'd3, 16'h00F0, WK_ANY_CLEAR, 1'b0, '0},
        '{MODE_WAIT, 3'd4, 16'hFFFF, WK_ALL_SET, 1'b0, '0},
        '{MODE_WAIT, 3'd5, 16'h1234, WK_ANY_SET, 1'b0, '0},
        '{MODE_WAIT, 3'd6, 16'h4000, WK_ALL_CLEAR, 1'b0, '0},
        '{MODE_WAIT, 3'd7, 16'hFFFF, WK_ANY_CLEAR, 1'b0, '0},
        '{MODE_SET, 3'd0, 16'hFFFF, WK_ALL_SET, 1'b0, '0}
    };

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic [MODE_W-1:0]    s_axis_tuser  = MODE_WAIT;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]    m_axis_tuser;
    logic                 m_axis_tlast;

    event_flag_group_engine u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Shadow of the engine state, advanced once per accepted input beat.
    logic [MASK_W-1:0]  flag_word;
    bit                 parked    [NSLOT];
    logic [MASK_W-1:0]  park_mask [NSLOT];
    logic [WKIND_W-1:0] park_kind [NSLOT];

    reply_t replies_due[$];
    int     mismatches  = 0;
    int     beats_seen  = 0;
    int     burst_left  = 1;

    function automatic bit waiter_matches(input logic [MASK_W-1:0] flags,
                                          input logic [MASK_W-1:0] mask,
                                          input logic [WKIND_W-1:0] wk,
                                          output logic [MASK_W-1:0] released);
        if (wk == WK_ALL_SET || wk == WK_ALL_CLEAR) begin
            released = mask;
            return (flags & mask) == mask;
        end
        released = flags & mask;
        return (flags & mask) != '0;
    endfunction

    function automatic bit clears_on_match(input logic [WKIND_W-1:0] wk);
        return wk == WK_ALL_CLEAR || wk == WK_ANY_CLEAR;
    endfunction

    // Mostly sparse masks, with the empty and the full mask now and then.
    function automatic logic [MASK_W-1:0] rand_mask();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            default: return MASK_W'($urandom) & MASK_W'($urandom);
        endcase
    endfunction

    // Advances the shadow state by one operation and queues the replies it owes.
    task automatic apply_flag_op(input logic [MODE_W-1:0] mode, input logic [WAITER_W-1:0] w,
                                 input logic [MASK_W-1:0] m, input logic [WKIND_W-1:0] wk);
        logic [MASK_W-1:0] rel;
        logic [MASK_W-1:0] after_scan;
        logic [MASK_W-1:0] woke_rel [NSLOT];
        bit                woke     [NSLOT];
        int                total;
        int                n;
        total = 0;
        n = 0;
        case (mode)
            MODE_WAIT: begin
                if (parked[w]) begin
                    replies_due.push_back('{KIND_ERROR, w, '0, flag_word, 1'b1});
                end else if (waiter_matches(flag_word, m, wk, rel)) begin
                    if (clears_on_match(wk)) flag_word &= ~m;
                    replies_due.push_back('{KIND_MATCHED, w, rel, flag_word, 1'b1});
                end else begin
                    parked[w] = 1'b1;
                    park_mask[w] = m;
                    park_kind[w] = wk;
                    replies_due.push_back('{KIND_BLOCKED, w, '0, flag_word, 1'b1});
                end
            end
            MODE_SET: begin
                // Every waiter sees the flags right after the OR; clears land after the scan.
                flag_word |= m;
                after_scan = flag_word;
                for (int i = 0; i < NSLOT; i++) begin
                    woke[i] = 1'b0;
                    woke_rel[i] = '0;
                    if (parked[i]) begin
                        if (waiter_matches(flag_word, park_mask[i], park_kind[i], rel)) begin
                            woke[i] = 1'b1;
                            woke_rel[i] = rel;
                            total++;
                            if (clears_on_match(park_kind[i])) after_scan &= ~(park_mask[i] & m);
                        end
                    end
                end
                flag_word = after_scan;
                if (total == 0) begin
                    replies_due.push_back('{KIND_DONE, '0, '0, flag_word, 1'b1});
                end else begin
                    for (int i = 0; i < NSLOT; i++) begin
                        if (woke[i]) begin
                            parked[i] = 1'b0;
                            replies_due.push_back('{KIND_WOKEN, SLOT_W'(i), woke_rel[i],
                                                    flag_word, n + 1 == total});
                            n++;
                        end
                    end
                end
            end
            MODE_CLEAR: begin
                flag_word &= ~m;
                replies_due.push_back('{KIND_DONE, '0, '0, flag_word, 1'b1});
            end
            default: begin
                if (!parked[w]) begin
                    replies_due.push_back('{KIND_ERROR, w, '0, flag_word, 1'b1});
                end else begin
                    parked[w] = 1'b0;
                    replies_due.push_back('{KIND_TIMEOUT, w, '0, flag_word, 1'b1});
                end
            end
        endcase
    endtask

    // Offers one beat, waits for the handshake, then at the end of a burst sometimes idles.
    task automatic offer_op(input logic [MODE_W-1:0] mode, input logic [WAITER_W-1:0] w,
                            input logic [MASK_W-1:0] m, input logic [WKIND_W-1:0] wk,
                            input logic typed, input reply_t typed_reply);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {3'b000, wk, m, w};
        do @(posedge aclk); while (!s_axis_tready);
        apply_flag_op(mode, w, m, wk);
        if (typed) replies_due[replies_due.size() - 1] = typed_reply;
        burst_left--;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 8);
        end
    endtask

    // Result side: checks each beat, and stalls in a randomly redrawn style (ready, coin flip, rarely).
    int rx_cycle    = 0;
    int stall_style = 0;
    int hold_left   = 0;
    bit held_once   = 1'b0;

    always @(posedge aclk) begin
        reply_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            beats_seen++;
            if (replies_due.size() == 0) begin
                $error("result beat with nothing expected: kind %0d slot %0d",
                       m_axis_tuser, m_axis_tdata[2:0]);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tdata[2:0] !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, m_axis_tdata[2:0]);
                    mismatches++;
                end
                if (m_axis_tdata[18:3] !== want.released) begin
                    $error("released_mask: expected %h, got %h", want.released,
                           m_axis_tdata[18:3]);
                    mismatches++;
                end
                if (m_axis_tdata[34:19] !== want.flags) begin
                    $error("flags_now: expected %h, got %h", want.flags, m_axis_tdata[34:19]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_axis_tlast);
                    mismatches++;
                end
            end
        end
        rx_cycle++;
        if (rx_cycle % 48 == 0) stall_style = $urandom_range(0, 2);
        // One long hold-off so that the engine backs up into its input.
        if (!held_once && beats_seen >= HOLD_AFTER) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_style)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog.
    int cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [MODE_W-1:0]   mode;
        logic [WAITER_W-1:0] w;
        logic [MASK_W-1:0]   m;
        logic [WKIND_W-1:0]  wk;
        int                  pick;
        int                  start;
        flag_word = '0;
        for (int i = 0; i < NSLOT; i++) begin
            parked[i] = 1'b0;
            park_mask[i] = '0;
            park_kind[i] = WK_ALL_SET;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < PLAN_ROWS; r++) begin
            offer_op(PLAN[r].mode, PLAN[r].waiter, PLAN[r].mask, PLAN[r].wkind,
                     PLAN[r].typed, PLAN[r].reply);
        end

        // Mostly well-formed traffic: waits on free slots and timeouts on parked ones,
        // with a share of misuse mixed in.
        for (int i = 0; i < RANDOM_OPS; i++) begin
            pick = $urandom_range(0, 99);
            w    = WAITER_W'($urandom_range(0, NSLOT - 1));
            m    = rand_mask();
            wk   = WKIND_W'($urandom_range(0, 3));
            if (pick < 35) begin
                mode = MODE_WAIT;
                if ($urandom_range(0, 9) != 0) begin
                    start = $urandom_range(0, NSLOT - 1);
                    for (int k = NSLOT - 1; k >= 0; k--) begin
                        if (!parked[(start + k) % NSLOT]) w = WAITER_W'((start + k) % NSLOT);
                    end
                end
            end else if (pick < 65) begin
                mode = MODE_SET;
            end else if (pick < 75) begin
                mode = MODE_CLEAR;
            end else begin
                mode = MODE_TIMEOUT;
                if ($urandom_range(0, 6) != 0) begin
                    start = $urandom_range(0, NSLOT - 1);
                    for (int k = NSLOT - 1; k >= 0; k--) begin
                        if (parked[(start + k) % NSLOT]) w = WAITER_W'((start + k) % NSLOT);
                    end
                end
            end
            offer_op(mode, w, m, wk, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (replies_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
